[src/pcm_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller with selectable modes: shared package
// Types, widths and codes used by the controller, the datapath and the top.
// ----------------------------------------------------------------------------
package pcm_pkg;

   // Width of a Q-format data word (measurement, gains, drive).
   localparam int DATA_W  = 32;
   // Width of the integral limit register.
   localparam int LIMIT_W = 31;
   // Shared multiplier operands and product.
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   // Drive accumulator; the three terms together stay far below this.
   localparam int SUM_W   = PROD_W + 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT     = 3'd6;

   // Controller modes.
   localparam logic [1:0] MODE_P   = 2'd0;
   localparam logic [1:0] MODE_PI  = 2'd1;
   localparam logic [1:0] MODE_PD  = 2'd2;
   localparam logic [1:0] MODE_PID = 2'd3;

   // Item kinds carried on the request user field.
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   // Limit on the derivative term and the saturation bounds of the drive.
   localparam logic signed [PROD_W-1:0] TERM_MAX  = PROD_W'(1) << 48;
   localparam logic signed [PROD_W-1:0] TERM_MIN  = -TERM_MAX;
   localparam logic signed [SUM_W-1:0]  DRIVE_MAX = SUM_W'(32'h7FFF_FFFF);
   localparam logic signed [SUM_W-1:0]  DRIVE_MIN = {{(SUM_W - 31){1'b1}}, 31'b0};

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ERROR,
      OP_MUL_P,
      OP_MUL_TS,
      OP_MUL_I,
      OP_MUL_DH,
      OP_MUL_DL,
      OP_ADD_PROD,
      OP_INTEG,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_END,
      OP_ADD_D,
      OP_FINISH
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type op;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic func;
      logic use_i;
      logic use_d;
      logic out_free;
   } status_type;

endpackage

[src/pcm_ctrl.sv]
// ----------------------------------------------------------------------------
// PID controller: sequencing state machine
// Steps one item through error, gain products, integral update, the
// derivative division and the final saturation, one datapath operation
// per cycle, holding in the final step until the result slot is free.
// ----------------------------------------------------------------------------
module pcm_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pcm_pkg::status_type status,
   output pcm_pkg::cmd_type    cmd
);
   import pcm_pkg::*;

   localparam int DIV_STEPS = 32 + FRAC_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_MUL_P,
      S_ADD_P,
      S_MUL_TS,
      S_INTEG,
      S_MUL_I,
      S_ADD_I,
      S_DIV_INIT,
      S_DIV_STEP,
      S_DIV_END,
      S_MUL_DH,
      S_MUL_DL,
      S_ADD_D,
      S_FINISH
   } state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  count_ff;

   assign req_tready = (state_ff == S_IDLE);

   // Operation for the current state.
   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:     cmd.op = req_tvalid ? OP_LOAD : OP_NONE;
         S_ERR:      cmd.op = (status.func == FUNC_CLEAR) ? OP_NONE : OP_ERROR;
         S_MUL_P:    cmd.op = OP_MUL_P;
         S_ADD_P:    cmd.op = OP_ADD_PROD;
         S_MUL_TS:   cmd.op = OP_MUL_TS;
         S_INTEG:    cmd.op = OP_INTEG;
         S_MUL_I:    cmd.op = OP_MUL_I;
         S_ADD_I:    cmd.op = OP_ADD_PROD;
         S_DIV_INIT: cmd.op = OP_DIV_INIT;
         S_DIV_STEP: cmd.op = OP_DIV_STEP;
         S_DIV_END:  cmd.op = OP_DIV_END;
         S_MUL_DH:   cmd.op = OP_MUL_DH;
         S_MUL_DL:   cmd.op = OP_MUL_DL;
         S_ADD_D:    cmd.op = OP_ADD_D;
         S_FINISH:   cmd.op = status.out_free ? OP_FINISH : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // State and divider step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) state_ff <= S_ERR;
            end
            S_ERR: begin
               state_ff <= (status.func == FUNC_CLEAR) ? S_FINISH : S_MUL_P;
            end
            S_MUL_P:  state_ff <= S_ADD_P;
            S_ADD_P: begin
               if (status.use_i)      state_ff <= S_MUL_TS;
               else if (status.use_d) state_ff <= S_DIV_INIT;
               else                   state_ff <= S_FINISH;
            end
            S_MUL_TS: state_ff <= S_INTEG;
            S_INTEG:  state_ff <= S_MUL_I;
            S_MUL_I:  state_ff <= S_ADD_I;
            S_ADD_I: begin
               state_ff <= status.use_d ? S_DIV_INIT : S_FINISH;
            end
            S_DIV_INIT: begin
               count_ff <= '0;
               state_ff <= S_DIV_STEP;
            end
            S_DIV_STEP: begin
               count_ff <= count_ff + STEP_W'(1);
               if (count_ff == STEP_W'(DIV_STEPS - 1)) state_ff <= S_DIV_END;
            end
            S_DIV_END: state_ff <= S_MUL_DH;
            S_MUL_DH:  state_ff <= S_MUL_DL;
            S_MUL_DL:  state_ff <= S_ADD_D;
            S_ADD_D:   state_ff <= S_FINISH;
            S_FINISH: begin
               if (status.out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[src/pcm_datapath.sv]
// ----------------------------------------------------------------------------
// PID controller: datapath
// Configuration registers, controller state, a shared 33x33 multiplier with
// a registered product, a restoring divider for the derivative and the
// registered result slot.
// ----------------------------------------------------------------------------
module pcm_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pcm_pkg::cmd_type                cmd,
   output pcm_pkg::status_type             status,
   input  logic [0:0]                      req_tuser,
   input  logic [pcm_pkg::DATA_W-1:0]      req_tdata,
   input  logic                            csr_valid,
   input  logic [pcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcm_pkg::DATA_W-1:0]      csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pcm_pkg::DATA_W-1:0]      rsp_tdata,
   output logic [0:0]                      rsp_tuser
);
   import pcm_pkg::*;

   localparam int DVD_W = DATA_W + FRAC_BITS;   // dividend and quotient
   localparam int DER_W = DVD_W + 1;            // signed derivative

   localparam logic [DATA_W-1:0]  TS_RESET    = DATA_W'(1) << FRAC_BITS;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100 << FRAC_BITS);
   localparam logic signed [PROD_W-1:0] HG_BOUND = PROD_W'(1) << (16 + FRAC_BITS);

   // Configuration.
   logic        [1:0]          mode_ff,   mode_in;
   logic signed [DATA_W-1:0]   target_ff, target_in;
   logic signed [DATA_W-1:0]   gp_ff,     gp_in;
   logic signed [DATA_W-1:0]   gi_ff,     gi_in;
   logic signed [DATA_W-1:0]   gd_ff,     gd_in;
   logic        [DATA_W-1:0]   ts_ff,     ts_in;
   logic        [LIMIT_W-1:0]  lim_ff,    lim_in;

   // Controller state.
   logic signed [DATA_W-1:0]   isum_ff,   isum_in;
   logic signed [DATA_W-1:0]   prev_ff,   prev_in;

   // Working registers.
   logic                       func_ff,   func_in;
   logic signed [DATA_W-1:0]   meas_ff,   meas_in;
   logic signed [DATA_W-1:0]   err_ff,    err_in;
   logic                       clip_ff,   clip_in;
   logic signed [PROD_W-1:0]   prod_ff,   prod_in;
   logic signed [PROD_W-1:0]   hg_ff,     hg_in;
   logic signed [SUM_W-1:0]    sum_ff,    sum_in;
   logic        [DATA_W-1:0]   rem_ff,    rem_in;
   logic        [DVD_W-1:0]    quo_ff,    quo_in;
   logic        [DATA_W-1:0]   dvs_ff,    dvs_in;
   logic                       neg_ff,    neg_in;
   logic signed [DER_W-1:0]    deriv_ff,  deriv_in;

   // Result slot.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   drive_ff,     drive_in;
   logic                       sat_ff,       sat_in;

   // Combinational helpers.
   logic signed [DATA_W:0]     err_wide;
   logic signed [DATA_W-1:0]   err_sat;
   logic                       err_clip;
   logic signed [DATA_W:0]     diff_wide;
   logic        [DATA_W:0]     diff_mag;
   logic        [DATA_W:0]     trial;
   logic                       trial_ge;
   logic        [DER_W:0]      quo_ext;
   logic signed [PROD_W-1:0]   prod_shr;
   logic signed [PROD_W-1:0]   acc;
   logic signed [PROD_W-1:0]   lim_s;
   logic signed [PROD_W-1:0]   acc_clamp;
   logic signed [PROD_W-1:0]   d_raw;
   logic signed [PROD_W-1:0]   d_term;
   logic signed [MUL_W-1:0]    mul_a;
   logic signed [MUL_W-1:0]    mul_b;
   logic                       mul_en;
   logic                       drv_hi;
   logic                       drv_lo;

   // Status to the controller.
   assign status.func     = func_ff;
   assign status.use_i    = (mode_ff == MODE_PI) || (mode_ff == MODE_PID);
   assign status.use_d    = (mode_ff == MODE_PD) || (mode_ff == MODE_PID);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = drive_ff;
   assign rsp_tuser[0] = sat_ff;

   // Error with saturation to the data width.
   assign err_wide = (DATA_W + 1)'(target_ff) - (DATA_W + 1)'(meas_ff);
   assign err_clip = err_wide[DATA_W] != err_wide[DATA_W-1];
   assign err_sat  = !err_clip ? err_wide[DATA_W-1:0] :
                     err_wide[DATA_W] ? {1'b1, {(DATA_W - 1){1'b0}}} :
                                        {1'b0, {(DATA_W - 1){1'b1}}};

   // Change in error, split into sign and magnitude for the divider.
   assign diff_wide = (DATA_W + 1)'(err_ff) - (DATA_W + 1)'(prev_ff);
   assign diff_mag  = diff_wide[DATA_W] ? -diff_wide : diff_wide;

   // One restoring division step.
   assign trial    = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_ge = trial >= {1'b0, dvs_ff};
   assign quo_ext  = {2'b00, quo_ff};

   // Product scaled back to the fixed-point grid, rounded toward minus infinity.
   assign prod_shr = prod_ff >>> FRAC_BITS;

   // Integral update and clamp.
   assign acc   = PROD_W'(isum_ff) + prod_shr;
   assign lim_s = $signed(PROD_W'(lim_ff));
   always_comb begin
      if (acc > lim_s)       acc_clamp = lim_s;
      else if (acc < -lim_s) acc_clamp = -lim_s;
      else                   acc_clamp = acc;
   end

   // Derivative term from its two partial products, limited to +/- 2^48.
   assign d_raw = (hg_ff <<< (32 - FRAC_BITS)) + prod_shr;
   always_comb begin
      if (hg_ff >= HG_BOUND)       d_term = TERM_MAX;
      else if (hg_ff <= -HG_BOUND) d_term = TERM_MIN;
      else if (d_raw > TERM_MAX)   d_term = TERM_MAX;
      else if (d_raw < TERM_MIN)   d_term = TERM_MIN;
      else                         d_term = d_raw;
   end

   // Drive saturation.
   assign drv_hi = sum_ff > DRIVE_MAX;
   assign drv_lo = sum_ff < DRIVE_MIN;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         OP_MUL_P: begin
            mul_a = MUL_W'(err_ff);
            mul_b = MUL_W'(gp_ff);
         end
         OP_MUL_TS: begin
            mul_a = MUL_W'(err_ff);
            mul_b = MUL_W'(ts_ff);
         end
         OP_MUL_I: begin
            mul_a = MUL_W'(isum_ff);
            mul_b = MUL_W'(gi_ff);
         end
         OP_MUL_DH: begin
            mul_a = MUL_W'($signed(deriv_ff[DER_W-1:32]));
            mul_b = MUL_W'(gd_ff);
         end
         OP_MUL_DL: begin
            mul_a = MUL_W'(deriv_ff[31:0]);
            mul_b = MUL_W'(gd_ff);
         end
         default: mul_en = 1'b0;
      endcase
   end

   // Next-state logic for all registers.
   always_comb begin
      mode_in      = mode_ff;
      target_in    = target_ff;
      gp_in        = gp_ff;
      gi_in        = gi_ff;
      gd_in        = gd_ff;
      ts_in        = ts_ff;
      lim_in       = lim_ff;
      isum_in      = isum_ff;
      prev_in      = prev_ff;
      func_in      = func_ff;
      meas_in      = meas_ff;
      err_in       = err_ff;
      clip_in      = clip_ff;
      hg_in        = hg_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      deriv_in     = deriv_ff;
      drive_in     = drive_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      prod_in      = mul_en ? mul_a * mul_b : prod_ff;

      case (cmd.op)
         OP_LOAD: begin
            func_in = req_tuser[0];
            meas_in = req_tdata;
         end
         OP_ERROR: begin
            err_in  = err_sat;
            clip_in = err_clip;
            sum_in  = '0;
         end
         OP_ADD_PROD: sum_in = sum_ff + SUM_W'(prod_shr);
         OP_INTEG:    isum_in = DATA_W'(acc_clamp);
         OP_DIV_INIT: begin
            rem_in = '0;
            quo_in = {diff_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            neg_in = diff_wide[DATA_W];
            dvs_in = (ts_ff == '0) ? DATA_W'(1) : ts_ff;
         end
         OP_DIV_STEP: begin
            rem_in = trial_ge ? DATA_W'(trial - {1'b0, dvs_ff}) : trial[DATA_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], trial_ge};
         end
         OP_DIV_END: begin
            deriv_in = neg_ff ? DER_W'(-$signed(quo_ext)) : DER_W'($signed(quo_ext));
         end
         OP_MUL_DL:  hg_in  = prod_ff;
         OP_ADD_D:   sum_in = sum_ff + SUM_W'(d_term);
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            if (func_ff == FUNC_CLEAR) begin
               drive_in = '0;
               sat_in   = 1'b0;
               isum_in  = '0;
               prev_in  = '0;
            end else begin
               drive_in = drv_hi ? DATA_W'(DRIVE_MAX) :
                          drv_lo ? DATA_W'(DRIVE_MIN) : DATA_W'(sum_ff);
               sat_in   = clip_ff || drv_hi || drv_lo;
               prev_in  = err_ff;
            end
         end
         default: ;
      endcase

      // Configuration writes; a new setpoint restarts the controller state.
      if (csr_valid) begin
         case (csr_index)
            REG_MODE:   mode_in = csr_data[1:0];
            REG_TARGET: begin
               target_in = csr_data;
               isum_in   = '0;
               prev_in   = '0;
            end
            REG_GAIN_P:    gp_in  = csr_data;
            REG_GAIN_I:    gi_in  = csr_data;
            REG_GAIN_D:    gd_in  = csr_data;
            REG_TIME_STEP: ts_in  = csr_data;
            REG_LIMIT:     lim_in = csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Registers with a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PID;
         target_ff    <= '0;
         gp_ff        <= '0;
         gi_ff        <= '0;
         gd_ff        <= '0;
         ts_ff        <= TS_RESET;
         lim_ff       <= LIMIT_RESET;
         isum_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         target_ff    <= target_in;
         gp_ff        <= gp_in;
         gi_ff        <= gi_in;
         gd_ff        <= gd_in;
         ts_ff        <= ts_in;
         lim_ff       <= lim_in;
         isum_ff      <= isum_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      meas_ff  <= meas_in;
      err_ff   <= err_in;
      clip_ff  <= clip_in;
      prod_ff  <= prod_in;
      hg_ff    <= hg_in;
      sum_ff   <= sum_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_ff   <= neg_in;
      deriv_ff <= deriv_in;
      drive_ff <= drive_in;
      sat_ff   <= sat_in;
   end

endmodule

[src/pid_controller_modes.sv]
// The steps an update runs through depend on the mode; a clear item skips from the error step
// straight to the finish, which zeroes the drive, the integral and the stored error.
// One item at a time: the next transfer is taken the cycle after the result is registered.
// The PD/PID steps add the restoring divider (one quotient bit per cycle, 32 +
// FRAC_BITS steps) and two more passes through the single shared multiplier. Synchronous
// reset restores the configuration registers, empties the result slot and zeroes the integral and the stored error.
// ----------------------------------------------------------------------------
// PID controller with selectable modes
// Positional P/PI/PD/PID controller in signed fixed point with integral
// clamp, derivative by division and 32-bit output saturation.
// ----------------------------------------------------------------------------
module pid_controller_modes #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pcm_pkg::DATA_W-1:0]    req_tdata,   // [31:0] measurement
   input  logic [0:0]                    req_tuser,   // [0] func
   // Result stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pcm_pkg::DATA_W-1:0]    rsp_tdata,   // [31:0] drive
   output logic [0:0]                    rsp_tuser,   // [0] saturated
   // Configuration writes.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcm_pkg::DATA_W-1:0]    csr_data
);
   import pcm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Registers accept a write in any cycle.
   assign csr_ready = 1'b1;

   pcm_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcm_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Only one item is in flight: an accepted transfer closes the input.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item was in flight");

   // The result slot is written only when it is free.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |-> status.out_free)
      else $error("result written over a pending result");

   // A finished item shows up on the result stream.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |=> rsp_tvalid)
      else $error("finished item not presented");

endmodule
